### rtl/pm_pkg.sv
// Package for the polynomial multiplier core: sizing constants, request
// codes, controller state type and the command/status structs.
// No dependencies.
package pm_pkg;

  // Storage sizing
  localparam int MAX_COEFFS = 32;
  localparam int COEFF_BITS = 24;

  // Fixed field widths of the channels
  localparam int REQ_W       = 2;
  localparam int IN_COEFF_W  = 24;
  localparam int OUT_COEFF_W = 56;
  localparam int OUT_IDX_W   = 6;

  // Derived widths
  localparam int ADDR_W     = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int CNT_W      = $clog2(MAX_COEFFS + 1);
  localparam int PROD_DEPTH = 2 * MAX_COEFFS - 1;
  localparam int IDX_W      = $clog2(PROD_DEPTH);
  localparam int WIDE_W     = IDX_W + 1;
  localparam int EXT_W      = (COEFF_BITS > IN_COEFF_W) ? COEFF_BITS : IN_COEFF_W;
  localparam int MUL_W      = 2 * COEFF_BITS;
  localparam int ACC_W      = MUL_W + $clog2(MAX_COEFFS) + 1;
  localparam int SAT_W      = (ACC_W > OUT_COEFF_W) ? ACC_W : OUT_COEFF_W;

  // Saturation bounds of the output coefficient
  localparam logic signed [SAT_W-1:0] SAT_HIGH =
    (SAT_W'(1) <<< (OUT_COEFF_W - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] SAT_LOW = -SAT_HIGH - SAT_W'(1);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_P  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_Q  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } pm_state_t;

  typedef struct packed {
    logic              wr_p;
    logic              wr_q;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_p;
    logic [ADDR_W-1:0] raddr_q;
    logic              issue;
    logic              acc_clr;
    logic              capture;
    logic              capture_zero;
    logic [IDX_W-1:0]  index;
    logic              last;
    logic              trunc;
  } pm_cmd_t;

  typedef struct packed {
    logic busy;
  } pm_status_t;

endpackage

### rtl/pm_in_if.sv
// Request channel: valid/ready handshake with request type and coefficient.
// Depends on pm_pkg.
interface pm_in_if;
  import pm_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [REQ_W-1:0]             req_type;
  logic signed [IN_COEFF_W-1:0] coefficient;

  modport source (output valid, output req_type, output coefficient, input ready);
  modport sink   (input valid, input req_type, input coefficient, output ready);
endinterface

### rtl/pm_out_if.sv
// Result channel: valid/ready handshake with one product coefficient.
// Depends on pm_pkg.
interface pm_out_if;
  import pm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [OUT_COEFF_W-1:0] product_coeff;
  logic [OUT_IDX_W-1:0]          coeff_index;
  logic                          last;
  logic                          zero_result;
  logic                          truncated;

  modport source (output valid, output product_coeff, output coeff_index,
                  output last, output zero_result, output truncated, input ready);
  modport sink   (input valid, input product_coeff, input coeff_index,
                  input last, input zero_result, input truncated, output ready);
endinterface

### rtl/pm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/pm_datapath.sv
// Datapath: operand RAMs, registered multiplier, accumulator, saturation
// and the result register. Depends on pm_pkg and pm_ram.
module pm_datapath
  import pm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  pm_pkg::pm_cmd_t               cmd,
  input  logic signed [pm_pkg::IN_COEFF_W-1:0] coefficient,
  output pm_pkg::pm_status_t            status,
  output logic signed [pm_pkg::OUT_COEFF_W-1:0] product_coeff,
  output logic [pm_pkg::OUT_IDX_W-1:0]  coeff_index,
  output logic                          last,
  output logic                          zero_result,
  output logic                          truncated
);
  import pm_pkg::*;

  logic signed [EXT_W-1:0]      coeff_ext;
  logic [COEFF_BITS-1:0]        wdata;
  logic [COEFF_BITS-1:0]        p_rdata;
  logic [COEFF_BITS-1:0]        q_rdata;
  logic signed [COEFF_BITS-1:0] p_op;
  logic signed [COEFF_BITS-1:0] q_op;
  logic signed [MUL_W-1:0]      mul;
  logic signed [ACC_W-1:0]      acc;
  logic signed [SAT_W-1:0]      acc_wide;
  logic signed [SAT_W-1:0]      acc_sat;
  logic                         rd_valid;
  logic                         mul_valid;

  // Take the low COEFF_BITS of the sign-extended field
  assign coeff_ext = EXT_W'(coefficient);
  assign wdata     = coeff_ext[COEFF_BITS-1:0];

  pm_ram #(.WIDTH(COEFF_BITS), .DEPTH(MAX_COEFFS)) u_p_ram (
    .clk   (clk),
    .we    (cmd.wr_p),
    .waddr (cmd.waddr),
    .wdata (wdata),
    .raddr (cmd.raddr_p),
    .rdata (p_rdata)
  );

  pm_ram #(.WIDTH(COEFF_BITS), .DEPTH(MAX_COEFFS)) u_q_ram (
    .clk   (clk),
    .we    (cmd.wr_q),
    .waddr (cmd.waddr),
    .wdata (wdata),
    .raddr (cmd.raddr_q),
    .rdata (q_rdata)
  );

  assign p_op = signed'(p_rdata);
  assign q_op = signed'(q_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
    end else begin
      rd_valid  <= cmd.issue;
      mul_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    mul <= p_op * q_op;
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (mul_valid) begin
      acc <= acc + ACC_W'(mul);
    end
  end

  assign status.busy = rd_valid | mul_valid;

  // Clamp to the output range
  always_comb begin
    acc_wide = SAT_W'(acc);
    if (acc_wide > SAT_HIGH) begin
      acc_sat = SAT_HIGH;
    end else if (acc_wide < SAT_LOW) begin
      acc_sat = SAT_LOW;
    end else begin
      acc_sat = acc_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_zero) begin
      product_coeff <= '0;
      coeff_index   <= '0;
      last          <= 1'b1;
      zero_result   <= 1'b1;
      truncated     <= cmd.trunc;
    end else if (cmd.capture) begin
      product_coeff <= acc_sat[OUT_COEFF_W-1:0];
      coeff_index   <= OUT_IDX_W'(cmd.index);
      last          <= cmd.last;
      zero_result   <= 1'b0;
      truncated     <= cmd.trunc;
    end
  end
endmodule

### rtl/pm_controller.sv
// Controller: operand counts, overflow flag, index sequencing and the state
// machine that drives the datapath. Depends on pm_pkg.
module pm_controller
  import pm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [pm_pkg::REQ_W-1:0] req_type,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  pm_pkg::pm_status_t      status,
  output pm_pkg::pm_cmd_t         cmd
);
  import pm_pkg::*;

  pm_state_t         state;
  pm_state_t         state_next;
  logic [CNT_W-1:0]  p_count;
  logic [CNT_W-1:0]  q_count;
  logic              overflow_seen;
  logic [IDX_W-1:0]  coeff_i;
  logic [ADDR_W-1:0] term_j;

  logic              in_fire;
  logic              out_fire;
  logic              empty;
  logic              p_full;
  logic              q_full;
  logic [WIDE_W-1:0] i_wide;
  logic [WIDE_W-1:0] i_inc;
  logic [WIDE_W-1:0] j_wide;
  logic [WIDE_W-1:0] p_wide;
  logic [WIDE_W-1:0] q_wide;
  logic [WIDE_W-1:0] j_high;
  logic [WIDE_W-1:0] j_low_next;
  logic [WIDE_W-1:0] q_addr_wide;
  logic              last_term;
  logic              last_coeff;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;
  assign empty    = (p_count == '0) || (q_count == '0);
  assign p_full   = (p_count == CNT_W'(MAX_COEFFS));
  assign q_full   = (q_count == CNT_W'(MAX_COEFFS));

  assign i_wide = WIDE_W'(coeff_i);
  assign i_inc  = i_wide + WIDE_W'(1);
  assign j_wide = WIDE_W'(term_j);
  assign p_wide = WIDE_W'(p_count);
  assign q_wide = WIDE_W'(q_count);

  // Highest term of coefficient i is min(i, p_count-1)
  assign j_high     = (i_wide < p_wide - WIDE_W'(1)) ? i_wide : p_wide - WIDE_W'(1);
  assign last_term  = (j_wide == j_high);
  assign last_coeff = (i_wide == p_wide + q_wide - WIDE_W'(2));
  // Lowest term of coefficient i+1 is max(0, i+1-(q_count-1))
  assign j_low_next = (i_inc + WIDE_W'(1) > q_wide) ?
                      (i_inc + WIDE_W'(1) - q_wide) : '0;
  assign q_addr_wide = i_wide - j_wide;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && req_type == REQ_COMPUTE) begin
          state_next = empty ? ST_OUT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (last_term) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // The lone zero result of an empty operand also ends the emission
        if (out_ready) begin
          state_next = (empty || last_coeff) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state == ST_IDLE);
    out_valid        = (state == ST_OUT);
    cmd              = '0;
    cmd.waddr        = p_count[ADDR_W-1:0];
    cmd.raddr_p      = term_j;
    cmd.raddr_q      = q_addr_wide[ADDR_W-1:0];
    cmd.index        = coeff_i;
    cmd.last         = last_coeff;
    cmd.trunc        = overflow_seen;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (req_type)
            REQ_LOAD_P: begin
              cmd.wr_p = ~p_full;
            end
            REQ_LOAD_Q: begin
              cmd.wr_q  = ~q_full;
              cmd.waddr = q_count[ADDR_W-1:0];
            end
            REQ_COMPUTE: begin
              cmd.capture_zero = empty;
              cmd.acc_clr      = ~empty;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd.capture = ~status.busy;
      end
      ST_OUT: begin
        // The held result carries last; start the next coefficient if not
        cmd.last    = last_coeff;
        cmd.acc_clr = out_ready & ~(empty | last_coeff);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      p_count       <= '0;
      q_count       <= '0;
      overflow_seen <= 1'b0;
      coeff_i       <= '0;
      term_j        <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (req_type)
              REQ_LOAD_P: begin
                if (p_full) overflow_seen <= 1'b1;
                else        p_count <= p_count + CNT_W'(1);
              end
              REQ_LOAD_Q: begin
                if (q_full) overflow_seen <= 1'b1;
                else        q_count <= q_count + CNT_W'(1);
              end
              REQ_COMPUTE: begin
                coeff_i <= '0;
                term_j  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_ISSUE: begin
          if (!last_term) begin
            term_j <= term_j + ADDR_W'(1);
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            if (empty || last_coeff) begin
              // Emission done: clear counts and flag
              p_count       <= '0;
              q_count       <= '0;
              overflow_seen <= 1'b0;
            end else begin
              coeff_i <= i_inc[IDX_W-1:0];
              term_j  <= j_low_next[ADDR_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/polynomial_multiplier_core.sv
// A compute request with an empty operand shows its single result in the cycle
// after it is accepted. Otherwise coefficient i issues the terms of its
// convolution sum, drains the RAM read and multiplier registers, is captured
// and waits for its handshake. One multiply-accumulate per cycle while terms
// issue, set by the single shared multiplier and RAM ports; paused otherwise.
// Reset (rst, synchronous): clears counts, overflow flag and state; stores hold.
module polynomial_multiplier_core (
  input logic clk,
  input logic rst,
  pm_in_if.sink   request,
  pm_out_if.source result
);
  import pm_pkg::*;

  // Command and status between the sequencer and the arithmetic
  pm_cmd_t    cmd;
  pm_status_t status;
  logic       out_valid;

  // Sequencer: counts loads, walks output index i and term j, and holds the
  // request channel while a product is being formed or delivered.
  pm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .req_type  (request.req_type),
    .in_ready  (request.ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic: operand RAMs read at p[j] and q[i-j], multiply, accumulate,
  // clamp, and hold the result register until the transaction completes.
  pm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .coefficient   (request.coefficient),
    .status        (status),
    .product_coeff (result.product_coeff),
    .coeff_index   (result.coeff_index),
    .last          (result.last),
    .zero_result   (result.zero_result),
    .truncated     (result.truncated)
  );

  assign result.valid = out_valid;
endmodule

### rtl/pm_checker.sv
// Port-level checker for the polynomial multiplier core, bound to the top.
// Depends on pm_pkg.
module pm_checker
  import pm_pkg::*;
(
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  req_ready,
  input logic                                  res_valid,
  input logic                                  res_ready,
  input logic signed [pm_pkg::OUT_COEFF_W-1:0] res_coeff,
  input logic [pm_pkg::OUT_IDX_W-1:0]          res_index,
  input logic                                  res_last,
  input logic                                  res_zero
);
  import pm_pkg::*;

  // Hold a stalled result steady
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_coeff) && $stable(res_index))
    else $error("stalled result changed");

  // No new request while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("request ready while result pending");

  // Empty-operand result is a lone zero at index 0
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_zero |-> res_last && res_index == '0 && res_coeff == '0)
    else $error("malformed zero result");

  // After the final coefficient, return to accepting requests
  a_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_last |=> !res_valid && req_ready)
    else $error("did not return to idle after last");
endmodule

bind polynomial_multiplier_core pm_checker u_pm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (request.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_coeff (result.product_coeff),
  .res_index (result.coeff_index),
  .res_last  (result.last),
  .res_zero  (result.zero_result)
);
